// File: rtl/core/i2a_pkg.sv
// i2a_pkg: types, codes and helpers shared by the integer to ascii formatter
// no dependencies
package i2a_pkg;

    localparam int VAL_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 11;
    localparam int DIG_W      = DIGIT_W * NUM_DIGITS;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * BCD_DIGITS;
    localparam int CNT_W      = 4;
    localparam int BIT_CNT_W  = 5;

    localparam logic [2:0] OP_CHAR = 3'd0;
    localparam logic [2:0] OP_SDEC = 3'd1;
    localparam logic [2:0] OP_UDEC = 3'd2;
    localparam logic [2:0] OP_OCT  = 3'd3;
    localparam logic [2:0] OP_HEXL = 3'd4;
    localparam logic [2:0] OP_HEXU = 3'd5;

    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    typedef struct packed {
        logic [2:0]       operation;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out;

    typedef struct packed {
        logic             char_mode;
        logic             upper;
        logic             neg;
        logic [7:0]       ch;
        logic [DIG_W-1:0] digits;
    } t_emit_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] f_digit_char(input logic [DIGIT_W-1:0] d,
                                                input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UP_A : CHAR_LOW_A;
        if (d < 4'd10) begin
            f_digit_char = CHAR_ZERO + {4'd0, d};
        end else begin
            f_digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// File: rtl/core/i2a_bcd.sv
// i2a_bcd: bit-serial binary to bcd converter, one input bit per cycle
// depends on i2a_pkg
module i2a_bcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [i2a_pkg::VAL_W-1:0] i_mag,
    output logic                      o_done,
    output logic [i2a_pkg::BCD_W-1:0] o_bcd
);

    logic [i2a_pkg::VAL_W-1:0]     r_mag;
    logic [i2a_pkg::BCD_W-1:0]     r_bcd;
    logic [i2a_pkg::BIT_CNT_W-1:0] r_cnt;
    logic                          r_run;
    logic                          r_done;
    logic [i2a_pkg::BCD_W-1:0]     adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < i2a_pkg::BCD_DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == i2a_pkg::BIT_CNT_W'(i2a_pkg::VAL_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_bcd <= '0;
        end else if (r_run) begin
            r_mag <= {r_mag[i2a_pkg::VAL_W-2:0], 1'b0};
            r_bcd <= {adj[i2a_pkg::BCD_W-2:0], r_mag[i2a_pkg::VAL_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// File: rtl/core/i2a_emit.sv
// i2a_emit: digit shift register, leading zero skip and output register
// depends on i2a_pkg
module i2a_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2a_pkg::t_emit_cmd i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output i2a_pkg::t_out      o_out
);

    logic                          r_busy, n_busy;
    logic [i2a_pkg::DIG_W-1:0]     r_dig, n_dig;
    logic [i2a_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_lead, n_lead;
    logic                          r_sign, n_sign;
    logic                          r_char_mode, n_char_mode;
    logic                          r_upper, n_upper;
    logic [7:0]                    r_ch, n_ch;
    logic                          r_ovalid, n_ovalid;
    i2a_pkg::t_out                 r_out, n_out;
    logic                          slot_free;
    logic                          emit;
    logic                          is_last;
    logic [i2a_pkg::DIGIT_W-1:0]   d;

    assign slot_free = !r_ovalid || !i_stall;
    assign d         = r_dig[i2a_pkg::DIG_W-1 -: i2a_pkg::DIGIT_W];
    assign is_last   = (r_cnt == i2a_pkg::CNT_W'(1));

    always_comb begin
        n_busy      = r_busy;
        n_dig       = r_dig;
        n_cnt       = r_cnt;
        n_lead      = r_lead;
        n_sign      = r_sign;
        n_char_mode = r_char_mode;
        n_upper     = r_upper;
        n_ch        = r_ch;
        n_out       = r_out;
        emit        = 1'b0;
        if (i_load) begin
            n_busy      = 1'b1;
            n_dig       = i_cmd.digits;
            n_cnt       = i2a_pkg::CNT_W'(i2a_pkg::NUM_DIGITS);
            n_lead      = 1'b1;
            n_sign      = i_cmd.neg;
            n_char_mode = i_cmd.char_mode;
            n_upper     = i_cmd.upper;
            n_ch        = i_cmd.ch;
        end else if (r_busy) begin
            priority if (r_char_mode) begin
                if (slot_free) begin
                    emit   = 1'b1;
                    n_out  = '{character: r_ch, last: 1'b1};
                    n_busy = 1'b0;
                end
            end else if (r_sign) begin
                if (slot_free) begin
                    emit   = 1'b1;
                    n_out  = '{character: i2a_pkg::CHAR_MINUS, last: 1'b0};
                    n_sign = 1'b0;
                end
            end else if (r_lead && d == '0 && !is_last) begin
                n_dig = {r_dig[i2a_pkg::DIG_W-i2a_pkg::DIGIT_W-1:0],
                         {i2a_pkg::DIGIT_W{1'b0}}};
                n_cnt = r_cnt - 1'b1;
            end else begin
                if (slot_free) begin
                    emit   = 1'b1;
                    n_out  = '{character: i2a_pkg::f_digit_char(d, r_upper),
                               last: is_last};
                    n_dig  = {r_dig[i2a_pkg::DIG_W-i2a_pkg::DIGIT_W-1:0],
                              {i2a_pkg::DIGIT_W{1'b0}}};
                    n_cnt  = r_cnt - 1'b1;
                    n_lead = 1'b0;
                    if (is_last) begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
        if (emit) begin
            n_ovalid = 1'b1;
        end else if (i_stall) begin
            n_ovalid = r_ovalid;
        end else begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig       <= n_dig;
        r_cnt       <= n_cnt;
        r_lead      <= n_lead;
        r_sign      <= n_sign;
        r_char_mode <= n_char_mode;
        r_upper     <= n_upper;
        r_ch        <= n_ch;
        r_out       <= n_out;
    end

    assign o_busy  = r_busy;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, mode decode and sequencing
// depends on i2a_pkg, i2a_bcd and i2a_emit
//
// Formats one 32-bit value per transfer as ASCII, most significant character
// first, one character per output transfer, with last set on the final one.
// Modes: character, signed decimal, unsigned decimal, octal, hex lower and
// hex upper; codes 6 and 7 are taken and give no output. One item is in work
// at a time. Decimal modes run a bit-serial binary to bcd converter, then
// the emitter steps through 11 digit slots at one per cycle while the output
// does not stall. Octal, hex and character modes skip the converter.
module integer_to_ascii_formatter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  i2a_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output i2a_pkg::t_out o_out
);

    i2a_pkg::t_state               r_state, n_state;
    logic                          r_neg, n_neg;
    logic                          accept;
    logic                          conv_start;
    logic [i2a_pkg::VAL_W-1:0]     conv_mag;
    logic                          conv_done;
    logic [i2a_pkg::BCD_W-1:0]     conv_bcd;
    logic                          emit_load;
    i2a_pkg::t_emit_cmd            emit_cmd;
    logic                          emit_busy;
    logic [i2a_pkg::VAL_W:0]       val_ext;

    assign o_stall = (r_state != i2a_pkg::ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign val_ext = {1'b0, i_in.value};

    always_comb begin
        n_state    = r_state;
        n_neg      = r_neg;
        conv_start = 1'b0;
        conv_mag   = i_in.value;
        emit_load  = 1'b0;
        emit_cmd   = '{char_mode: 1'b0, upper: 1'b0, neg: 1'b0, ch: i_in.value[7:0],
                       digits: {{(i2a_pkg::DIG_W-i2a_pkg::VAL_W){1'b0}}, i_in.value}};
        unique case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.operation)
                        i2a_pkg::OP_CHAR: begin
                            emit_load          = 1'b1;
                            emit_cmd.char_mode = 1'b1;
                            n_state            = i2a_pkg::ST_EMIT;
                        end
                        i2a_pkg::OP_SDEC, i2a_pkg::OP_UDEC: begin
                            n_neg = (i_in.operation == i2a_pkg::OP_SDEC) &&
                                    i_in.value[i2a_pkg::VAL_W-1];
                            conv_start = 1'b1;
                            if (n_neg) begin
                                conv_mag = '0 - i_in.value;
                            end
                            n_state = i2a_pkg::ST_CONV;
                        end
                        i2a_pkg::OP_OCT: begin
                            emit_load = 1'b1;
                            for (int k = 0; k < i2a_pkg::NUM_DIGITS; k++) begin
                                emit_cmd.digits[k*4 +: 4] = {1'b0, val_ext[k*3 +: 3]};
                            end
                            n_state = i2a_pkg::ST_EMIT;
                        end
                        i2a_pkg::OP_HEXL, i2a_pkg::OP_HEXU: begin
                            emit_load      = 1'b1;
                            emit_cmd.upper = (i_in.operation == i2a_pkg::OP_HEXU);
                            n_state        = i2a_pkg::ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            i2a_pkg::ST_CONV: begin
                if (conv_done) begin
                    emit_load       = 1'b1;
                    emit_cmd.neg    = r_neg;
                    emit_cmd.digits = {{(i2a_pkg::DIG_W-i2a_pkg::BCD_W){1'b0}}, conv_bcd};
                    n_state         = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
    end

    i2a_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_mag   (conv_mag),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    i2a_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .i_cmd   (emit_cmd),
        .o_busy  (emit_busy),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    a_conv_emit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2a_pkg::ST_CONV) |-> !emit_busy)
        else $error("emitter busy during conversion");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == i2a_pkg::ST_CONV))
        else $error("conversion finished outside conversion state");

    a_numeric_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.operation == i2a_pkg::OP_SDEC ||
                    i_in.operation == i2a_pkg::OP_UDEC)) |=>
        (r_state == i2a_pkg::ST_CONV && o_stall))
        else $error("decimal item did not start conversion");

endmodule

// File: tb/sv/integer_to_ascii_formatter_tb.sv
// integer_to_ascii_formatter_tb: self-checking bench for the integer to ascii formatter
// drives a directed table and then random conversions; every character is checked in order
// depends on i2a_pkg and integer_to_ascii_formatter
module integer_to_ascii_formatter_tb;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 120;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
    localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
        logic        typed;
        logic [87:0] txt;
    } t_row;

    localparam int NUM_ROWS = 24;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{i2a_pkg::OP_CHAR, 32'h0000_0041, 1'b1, "A"},
        '{i2a_pkg::OP_CHAR, 32'hFFFF_FF00, 1'b0, 88'd0},
        '{i2a_pkg::OP_CHAR, 32'h0000_00FF, 1'b0, 88'd0},
        '{i2a_pkg::OP_SDEC, 32'h0000_0000, 1'b1, "0"},
        '{i2a_pkg::OP_SDEC, 32'h8000_0000, 1'b1, "-2147483648"},
        '{i2a_pkg::OP_SDEC, 32'h7FFF_FFFF, 1'b1, "2147483647"},
        '{i2a_pkg::OP_SDEC, 32'hFFFF_FFFF, 1'b1, "-1"},
        '{i2a_pkg::OP_SDEC, 32'h0000_007B, 1'b0, 88'd0},
        '{i2a_pkg::OP_UDEC, 32'h0000_0000, 1'b1, "0"},
        '{i2a_pkg::OP_UDEC, 32'hFFFF_FFFF, 1'b1, "4294967295"},
        '{i2a_pkg::OP_UDEC, 32'h8000_0000, 1'b1, "2147483648"},
        '{i2a_pkg::OP_UDEC, 32'd1000000000, 1'b0, 88'd0},
        '{i2a_pkg::OP_OCT,  32'h0000_0000, 1'b1, "0"},
        '{i2a_pkg::OP_OCT,  32'hFFFF_FFFF, 1'b1, "37777777777"},
        '{i2a_pkg::OP_OCT,  32'h0000_0008, 1'b1, "10"},
        '{i2a_pkg::OP_HEXL, 32'h0000_0000, 1'b1, "0"},
        '{i2a_pkg::OP_HEXL, 32'hFFFF_FFFF, 1'b1, "ffffffff"},
        '{i2a_pkg::OP_HEXL, 32'hDEAD_BEEF, 1'b1, "deadbeef"},
        '{i2a_pkg::OP_HEXU, 32'hFFFF_FFFF, 1'b1, "FFFFFFFF"},
        '{i2a_pkg::OP_HEXU, 32'h0000_ABCD, 1'b1, "ABCD"},
        '{i2a_pkg::OP_HEXU, 32'h0000_0000, 1'b1, "0"},
        '{OP_RSVD6, 32'h1234_5678, 1'b1, 88'd0},
        '{OP_RSVD7, 32'hFFFF_FFFF, 1'b1, 88'd0},
        '{i2a_pkg::OP_SDEC, 32'h0000_0009, 1'b0, 88'd0}
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    i2a_pkg::t_in  i_in;
    logic          o_valid;
    logic          i_stall;
    i2a_pkg::t_out o_out;

    i2a_pkg::t_out pending_chars[$];
    i2a_pkg::t_out want;
    int   errors;
    int   cycles;
    int   phase;
    bit   long_hold_done;

    integer_to_ascii_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // characters of one conversion, most significant first, onto the pending queue
    function automatic void predict_text(input logic [2:0] op, input logic [31:0] val);
        logic [7:0]  rev [0:11];
        logic [31:0] mag;
        logic [3:0]  dig;
        int unsigned radix;
        bit          upper;
        bit          neg;
        int          n;
        n = 0;
        upper = (op == i2a_pkg::OP_HEXU);
        case (op)
            i2a_pkg::OP_CHAR: begin
                rev[0] = val[7:0];
                n = 1;
            end
            i2a_pkg::OP_SDEC, i2a_pkg::OP_UDEC, i2a_pkg::OP_OCT, i2a_pkg::OP_HEXL,
            i2a_pkg::OP_HEXU: begin
                if (op == i2a_pkg::OP_OCT) begin
                    radix = 8;
                end else if (op == i2a_pkg::OP_HEXL || op == i2a_pkg::OP_HEXU) begin
                    radix = 16;
                end else begin
                    radix = 10;
                end
                neg = (op == i2a_pkg::OP_SDEC) && val[31];
                mag = neg ? (32'd0 - val) : val;
                do begin
                    dig = 4'(mag % radix);
                    rev[n] = upper ? UPPER_DIGITS[(15 - dig) * 8 +: 8]
                                   : LOWER_DIGITS[(15 - dig) * 8 +: 8];
                    mag = mag / radix;
                    n++;
                end while (mag != 0);
                if (neg) begin
                    rev[n] = i2a_pkg::CHAR_MINUS;
                    n++;
                end
            end
            default: n = 0;
        endcase
        for (int k = 0; k < n; k++) begin
            pending_chars.push_back('{character: rev[n - 1 - k], last: (k == n - 1)});
        end
    endfunction

    // offer one conversion from a falling edge, return at the falling edge after the transfer
    task automatic send_item(input logic [2:0] op, input logic [31:0] val,
                             input logic typed, input logic [87:0] txt);
        logic [7:0] ch [0:10];
        int         n;
        int         idle_pct;
        idle_pct = (phase == 0) ? 36 : (phase == 1) ? 63 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= '{operation: op, value: val};
        do @(posedge i_clk); while (o_stall);
        if (typed) begin
            n = 0;
            for (int i = 10; i >= 0; i--) begin
                if (txt[i * 8 +: 8] != 8'd0) begin
                    ch[n] = txt[i * 8 +: 8];
                    n++;
                end
            end
            for (int k = 0; k < n; k++) begin
                pending_chars.push_back('{character: ch[k], last: (k == n - 1)});
            end
        end else begin
            predict_text(op, val);
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: got %h last %b", $time,
                         o_out.character, o_out.last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_out.character !== want.character) begin
                    $display("%0t: character mismatch: expected %h got %h", $time,
                             want.character, o_out.character);
                    errors++;
                end
                if (o_out.last !== want.last) begin
                    $display("%0t: last mismatch: expected %b got %b", $time,
                             want.last, o_out.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("integer_to_ascii_formatter_tb NOT OK");
            $finish;
        end
    end

    // receiver side: random stall, one long hold once the no-idle phase starts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == 2 && !long_hold_done) begin
                i_stall <= 1'b1;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (phase == 0) begin
                i_stall <= ($urandom_range(0, 99) < 63);
            end else if (phase == 1) begin
                i_stall <= ($urandom_range(0, 99) < 36);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [2:0]  op;
        logic [31:0] val;
        int          sent;
        errors = 0;
        cycles = 0;
        phase = 0;
        long_hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].val,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].txt);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = sent / ITEMS_PER_PHASE;
            if ($urandom_range(0, 19) == 0) begin
                op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
            end else begin
                op = 3'($urandom_range(i2a_pkg::OP_CHAR, i2a_pkg::OP_HEXU));
                sent++;
            end
            case ($urandom_range(0, 5))
                0, 1: val = $urandom;
                2: val = $urandom >> $urandom_range(0, 31);
                3: val = $urandom_range(0, 20);
                4: begin
                    case ($urandom_range(0, 3))
                        0: val = 32'h0000_0000;
                        1: val = 32'h8000_0000;
                        2: val = 32'hFFFF_FFFF;
                        default: val = 32'h7FFF_FFFF;
                    endcase
                end
                default: val = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
            endcase
            send_item(op, val, 1'b0, 88'd0);
        end
        i_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("integer_to_ascii_formatter_tb OK");
        end else begin
            $display("integer_to_ascii_formatter_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_bcd.sv
rtl/core/i2a_emit.sv
rtl/core/integer_to_ascii_formatter.sv
tb/sv/integer_to_ascii_formatter_tb.sv
